// ----- design/thermistor_adc_to_centi_celsius_defines.svh -----
// ----------------------------------------------------------------------------
// thermistor_adc_to_centi_celsius_defines
// assertion macros used by the thermistor converter rtl
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_ADC_TO_CENTI_CELSIUS_DEFINES_SVH
`define THERMISTOR_ADC_TO_CENTI_CELSIUS_DEFINES_SVH

// same-cycle implication
`define TAC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tac assertion failed");

// next-cycle implication
`define TAC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tac assertion failed");

`endif

// ----- design/tac_pkg.sv -----
// ----------------------------------------------------------------------------
// tac_pkg
// constants and types of the thermistor code to centidegree converter
// ----------------------------------------------------------------------------
package tac_pkg;

    // widths of the external fields
    localparam int ADC_BITS_DEF = 10;
    localparam int RES_W        = 20;
    localparam int BETA_W       = 14;
    localparam int TEMP_W       = 17;
    localparam int FRAC_W       = 32;
    localparam int CFG_IDX_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 2'd2;

    // register reset values
    localparam logic [RES_W-1:0]  FIXED_RST   = 20'd6800;
    localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd10000;
    localparam logic [BETA_W-1:0] BETA_RST    = 14'd3950;

    // fixed-point constants
    localparam logic [FRAC_W-1:0] LN2_Q32    = 32'hB17217F8;
    localparam logic [63:0]       INV_T0_Q40 = ((64'd20 << 40) + 64'd2981) / 64'd5963;
    localparam int                T_NUM_W    = 47;
    localparam logic [T_NUM_W-1:0] T_NUM     = 47'(64'd100 << 40);
    localparam int                T_LIMIT    = 67315;

    // result limits
    localparam logic signed [TEMP_W-1:0] TEMP_MIN     = -17'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 17'sd40000;
    localparam logic signed [TEMP_W:0]   CENTI_OFFSET = 18'sd27315;

    // per-item status travelling down the pipe
    typedef struct packed {
        logic fault;
        logic spec;
    } t_flags;

endpackage

// ----- design/thermistor_adc_to_centi_celsius.sv -----
// ----------------------------------------------------------------------------
// thermistor_adc_to_centi_celsius
// thermistor divider code to temperature in hundredths of a degree celsius
// ----------------------------------------------------------------------------
// pipeline: stage 1, stage 2, the 32 log cells, stages 3 to 5, the beta division row,
//   stage 6, the temperature division row and the output register, from accept to o_valid
// throughput: one item per cycle; the whole row holds while a result is stalled
// reset: synchronous active low, clears all valid bits and loads the register
//   defaults; no clearing pass
// ----------------------------------------------------------------------------
`include "thermistor_adc_to_centi_celsius_defines.svh"

module thermistor_adc_to_centi_celsius #(
    parameter int ADC_BITS = tac_pkg::ADC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [ADC_BITS-1:0]                i_adc_code,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [tac_pkg::TEMP_W-1:0]  o_temp_centi_c,
    output logic                               o_sensor_fault,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tac_pkg::RES_W-1:0]          i_cfg_data
);

    localparam int WP    = tac_pkg::RES_W + ADC_BITS;
    localparam int E_W   = $clog2(WP);
    localparam int L_W   = E_W + tac_pkg::FRAC_W;
    localparam int NW1   = L_W + 8;
    localparam int DW1   = tac_pkg::BETA_W;
    localparam int IT_W  = NW1 + 2;
    localparam int DW2   = IT_W - 1;
    localparam int NW2   = tac_pkg::T_NUM_W;
    localparam int N_LOG = tac_pkg::FRAC_W;
    localparam logic [ADC_BITS-1:0] MAXC = '1;

    // configuration registers
    logic [tac_pkg::RES_W-1:0]  r_fixed;
    logic [tac_pkg::RES_W-1:0]  r_nominal;
    logic [tac_pkg::BETA_W-1:0] r_beta;
    logic [tac_pkg::BETA_W-1:0] w_beta_eff;

    logic w_en;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !o_valid || !i_stall;
    assign o_stall     = !w_en;
    assign w_beta_eff  = (r_beta == '0) ? tac_pkg::BETA_W'(1) : r_beta;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed   <= tac_pkg::FIXED_RST;
            r_nominal <= tac_pkg::NOMINAL_RST;
            r_beta    <= tac_pkg::BETA_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tac_pkg::CFG_FIXED:   r_fixed   <= i_cfg_data;
                tac_pkg::CFG_NOMINAL: r_nominal <= i_cfg_data;
                tac_pkg::CFG_BETA:    r_beta    <= i_cfg_data[tac_pkg::BETA_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: divider products and special cases
    logic            r1_v;
    tac_pkg::t_flags r1_flags;
    tac_pkg::t_flags n1_flags;
    logic [WP-1:0]   r1_a;
    logic [WP-1:0]   r1_b;

    always_comb begin
        n1_flags.fault = (i_adc_code == '0) || (i_adc_code == MAXC);
        n1_flags.spec  = n1_flags.fault || (r_fixed == '0) || (r_nominal == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_flags <= n1_flags;
            r1_a     <= WP'(r_fixed) * WP'(i_adc_code);
            r1_b     <= WP'(r_nominal) * WP'(MAXC - i_adc_code);
        end
    end

    // stage 2: exponent and mantissa alignment
    function automatic logic [L_W-1:0] f_norm(input logic [WP-1:0] n);
        logic [E_W-1:0] e;
        logic [WP-1:0]  x;
        logic [63:0]    ext;
        e = '0;
        for (int i = 0; i < WP; i++) begin
            if (n[i]) begin
                e = E_W'(i);
            end
        end
        x   = n << (E_W'(WP - 1) - e);
        ext = {x, {(64 - WP){1'b0}}};
        return {e, ext[63:32]};
    endfunction

    logic            r2_v;
    tac_pkg::t_flags r2_flags;
    logic [L_W-1:0]  r2_na;
    logic [L_W-1:0]  r2_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_flags <= r1_flags;
            r2_na    <= f_norm(r1_a);
            r2_nb    <= f_norm(r1_b);
        end
    end

    // log2 fraction row
    logic                       w_lv  [0:N_LOG];
    tac_pkg::t_flags            w_lf  [0:N_LOG];
    logic [E_W-1:0]             w_lea [0:N_LOG];
    logic [E_W-1:0]             w_leb [0:N_LOG];
    logic [tac_pkg::FRAC_W-1:0] w_lma [0:N_LOG];
    logic [tac_pkg::FRAC_W-1:0] w_lmb [0:N_LOG];
    logic [tac_pkg::FRAC_W-1:0] w_lfa [0:N_LOG];
    logic [tac_pkg::FRAC_W-1:0] w_lfb [0:N_LOG];

    assign w_lv[0]  = r2_v;
    assign w_lf[0]  = r2_flags;
    assign w_lea[0] = r2_na[L_W-1:tac_pkg::FRAC_W];
    assign w_leb[0] = r2_nb[L_W-1:tac_pkg::FRAC_W];
    assign w_lma[0] = r2_na[tac_pkg::FRAC_W-1:0];
    assign w_lmb[0] = r2_nb[tac_pkg::FRAC_W-1:0];
    assign w_lfa[0] = '0;
    assign w_lfb[0] = '0;

    for (genvar g = 0; g < N_LOG; g++) begin : g_log
        tac_log_cell #(.E_W(E_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_lv[g]),
            .i_flags (w_lf[g]),
            .i_e_a   (w_lea[g]),
            .i_e_b   (w_leb[g]),
            .i_m_a   (w_lma[g]),
            .i_m_b   (w_lmb[g]),
            .i_fr_a  (w_lfa[g]),
            .i_fr_b  (w_lfb[g]),
            .o_valid (w_lv[g+1]),
            .o_flags (w_lf[g+1]),
            .o_e_a   (w_lea[g+1]),
            .o_e_b   (w_leb[g+1]),
            .o_m_a   (w_lma[g+1]),
            .o_m_b   (w_lmb[g+1]),
            .o_fr_a  (w_lfa[g+1]),
            .o_fr_b  (w_lfb[g+1])
        );
    end

    // stage 3: log ratio magnitude and sign
    logic [L_W-1:0]  w_la;
    logic [L_W-1:0]  w_lb;
    logic            r3_v;
    tac_pkg::t_flags r3_flags;
    logic            r3_neg;
    logic [L_W-1:0]  r3_mag;

    assign w_la = {w_lea[N_LOG], w_lfa[N_LOG]};
    assign w_lb = {w_leb[N_LOG], w_lfb[N_LOG]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_lv[N_LOG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_flags <= w_lf[N_LOG];
            r3_neg   <= (w_la < w_lb);
            r3_mag   <= (w_la < w_lb) ? (w_lb - w_la) : (w_la - w_lb);
        end
    end

    // stage 4: products with ln2
    logic                         r4_v;
    tac_pkg::t_flags              r4_flags;
    logic                         r4_neg;
    logic [L_W-1:0]               r4_phi;
    logic [2*tac_pkg::FRAC_W-1:0] r4_plo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_flags <= r3_flags;
            r4_neg   <= r3_neg;
            r4_phi   <= L_W'(r3_mag[L_W-1:tac_pkg::FRAC_W]) * L_W'(tac_pkg::LN2_Q32);
            r4_plo   <= (2*tac_pkg::FRAC_W)'(r3_mag[tac_pkg::FRAC_W-1:0])
                        * (2*tac_pkg::FRAC_W)'(tac_pkg::LN2_Q32);
        end
    end

    // stage 5: natural log magnitude
    logic            r5_v;
    tac_pkg::t_flags r5_flags;
    logic            r5_neg;
    logic [L_W-1:0]  r5_lnx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_flags <= r4_flags;
            r5_neg   <= r4_neg;
            r5_lnx   <= r4_phi + L_W'(r4_plo[63:32]);
        end
    end

    // beta division row
    logic           w_v1 [0:NW1];
    logic [DW1-1:0] w_r1 [0:NW1];
    logic [NW1-1:0] w_q1 [0:NW1];
    logic [DW1-1:0] w_d1 [0:NW1];
    logic [2:0]     w_s1 [0:NW1];

    assign w_v1[0] = r5_v;
    assign w_r1[0] = '0;
    assign w_q1[0] = {r5_lnx, 8'd0};
    assign w_d1[0] = w_beta_eff;
    assign w_s1[0] = {r5_neg, r5_flags};

    for (genvar g = 0; g < NW1; g++) begin : g_div1
        tac_div_cell #(.NW(NW1), .DW(DW1), .SW(3)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v1[g]),
            .i_rem   (w_r1[g]),
            .i_qd    (w_q1[g]),
            .i_div   (w_d1[g]),
            .i_side  (w_s1[g]),
            .o_valid (w_v1[g+1]),
            .o_rem   (w_r1[g+1]),
            .o_qd    (w_q1[g+1]),
            .o_div   (w_d1[g+1]),
            .o_side  (w_s1[g+1])
        );
    end

    // stage 6: inverse temperature
    logic [IT_W-1:0] w_inv;
    tac_pkg::t_flags w_f1;
    tac_pkg::t_flags n6_flags;
    logic            r6_v;
    tac_pkg::t_flags r6_flags;
    logic [DW2-1:0]  r6_inv;

    always_comb begin
        w_f1  = tac_pkg::t_flags'(w_s1[NW1][1:0]);
        w_inv = w_s1[NW1][2] ? (IT_W'(tac_pkg::INV_T0_Q40) - {2'b00, w_q1[NW1]})
                             : (IT_W'(tac_pkg::INV_T0_Q40) + {2'b00, w_q1[NW1]});
        n6_flags.fault = w_f1.fault;
        n6_flags.spec  = w_f1.spec || w_inv[IT_W-1] || (w_inv == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= w_v1[NW1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_flags <= n6_flags;
            r6_inv   <= w_inv[DW2-1:0];
        end
    end

    // temperature division row
    logic           w_v2 [0:NW2];
    logic [DW2-1:0] w_r2 [0:NW2];
    logic [NW2-1:0] w_q2 [0:NW2];
    logic [DW2-1:0] w_d2 [0:NW2];
    logic [1:0]     w_s2 [0:NW2];

    assign w_v2[0] = r6_v;
    assign w_r2[0] = '0;
    assign w_q2[0] = tac_pkg::T_NUM;
    assign w_d2[0] = r6_inv;
    assign w_s2[0] = r6_flags;

    for (genvar g = 0; g < NW2; g++) begin : g_div2
        tac_div_cell #(.NW(NW2), .DW(DW2), .SW(2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v2[g]),
            .i_rem   (w_r2[g]),
            .i_qd    (w_q2[g]),
            .i_div   (w_d2[g]),
            .i_side  (w_s2[g]),
            .o_valid (w_v2[g+1]),
            .o_rem   (w_r2[g+1]),
            .o_qd    (w_q2[g+1]),
            .o_div   (w_d2[g+1]),
            .o_side  (w_s2[g+1])
        );
    end

    // output stage: offset, truncation toward zero and saturation
    tac_pkg::t_flags                   w_f2;
    logic signed [tac_pkg::TEMP_W:0]   w_diff;
    logic signed [tac_pkg::TEMP_W-1:0] n_temp;

    always_comb begin
        w_f2   = tac_pkg::t_flags'(w_s2[NW2]);
        w_diff = $signed({1'b0, w_q2[NW2][tac_pkg::TEMP_W-1:0]}) - tac_pkg::CENTI_OFFSET;
        if (w_diff[tac_pkg::TEMP_W] && (w_r2[NW2] != '0)) begin
            w_diff = w_diff + 18'sd1;
        end
        if (w_f2.spec) begin
            n_temp = tac_pkg::TEMP_MIN;
        end else if (w_q2[NW2] > NW2'(tac_pkg::T_LIMIT)) begin
            n_temp = tac_pkg::TEMP_MAX;
        end else begin
            n_temp = w_diff[tac_pkg::TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_v2[NW2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_temp_centi_c <= n_temp;
            o_sensor_fault <= w_f2.fault;
        end
    end

    // checks
    `TAC_ASSERT_IMP(a_fault_min, o_valid && o_sensor_fault, o_temp_centi_c == tac_pkg::TEMP_MIN)
    `TAC_ASSERT_IMP(a_range, o_valid, (o_temp_centi_c >= tac_pkg::TEMP_MIN) && (o_temp_centi_c <= tac_pkg::TEMP_MAX))
    `TAC_ASSERT_IMP(a_hold_in, o_valid && i_stall, o_stall)
    `TAC_ASSERT_NXT(a_cfg_beta, i_cfg_valid && (i_cfg_index == tac_pkg::CFG_BETA), r_beta == $past(i_cfg_data[tac_pkg::BETA_W-1:0]))

endmodule

// ----- design/tac_log_cell.sv -----
// ----------------------------------------------------------------------------
// tac_log_cell
// one squaring step of the log2 fraction for both divider products
// ----------------------------------------------------------------------------
module tac_log_cell #(
    parameter int E_W = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  tac_pkg::t_flags             i_flags,
    input  logic [E_W-1:0]              i_e_a,
    input  logic [E_W-1:0]              i_e_b,
    input  logic [tac_pkg::FRAC_W-1:0]  i_m_a,
    input  logic [tac_pkg::FRAC_W-1:0]  i_m_b,
    input  logic [tac_pkg::FRAC_W-1:0]  i_fr_a,
    input  logic [tac_pkg::FRAC_W-1:0]  i_fr_b,
    output logic                        o_valid,
    output tac_pkg::t_flags             o_flags,
    output logic [E_W-1:0]              o_e_a,
    output logic [E_W-1:0]              o_e_b,
    output logic [tac_pkg::FRAC_W-1:0]  o_m_a,
    output logic [tac_pkg::FRAC_W-1:0]  o_m_b,
    output logic [tac_pkg::FRAC_W-1:0]  o_fr_a,
    output logic [tac_pkg::FRAC_W-1:0]  o_fr_b
);

    logic [2*tac_pkg::FRAC_W-1:0] w_sq_a;
    logic [2*tac_pkg::FRAC_W-1:0] w_sq_b;
    logic [tac_pkg::FRAC_W-1:0]   n_m_a;
    logic [tac_pkg::FRAC_W-1:0]   n_m_b;
    logic [tac_pkg::FRAC_W-1:0]   n_fr_a;
    logic [tac_pkg::FRAC_W-1:0]   n_fr_b;

    // square, renormalise to [1,2) and shift the fraction bit in
    always_comb begin
        w_sq_a = i_m_a * i_m_a;
        w_sq_b = i_m_b * i_m_b;
        n_m_a  = w_sq_a[63] ? w_sq_a[63:32] : w_sq_a[62:31];
        n_m_b  = w_sq_b[63] ? w_sq_b[63:32] : w_sq_b[62:31];
        n_fr_a = {i_fr_a[30:0], w_sq_a[63]};
        n_fr_b = {i_fr_b[30:0], w_sq_b[63]};
    end

    // valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_flags <= i_flags;
            o_e_a   <= i_e_a;
            o_e_b   <= i_e_b;
            o_m_a   <= n_m_a;
            o_m_b   <= n_m_b;
            o_fr_a  <= n_fr_a;
            o_fr_b  <= n_fr_b;
        end
    end

endmodule

// ----- design/tac_div_cell.sv -----
// ----------------------------------------------------------------------------
// tac_div_cell
// one restoring division step, quotient bit shifted into the dividend word
// ----------------------------------------------------------------------------
module tac_div_cell #(
    parameter int NW = 45,
    parameter int DW = 14,
    parameter int SW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_qd,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_qd,
    output logic [DW-1:0] o_div,
    output logic [SW-1:0] o_side
);

    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] n_qd;

    // trial subtract
    always_comb begin
        w_trial = {i_rem, i_qd[NW-1]};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? DW'(w_trial - {1'b0, i_div}) : w_trial[DW-1:0];
        n_qd    = {i_qd[NW-2:0], w_ge};
    end

    // valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_qd   <= n_qd;
            o_div  <= i_div;
            o_side <= i_side;
        end
    end

endmodule
